@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define FIR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// checked at every edge, reset included
`define FIR_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define FIR_ASSERT(name, clk, rst_n, prop)
`define FIR_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ hw/rtl/fir_pkg.sv @@
// types and constants of the circular fir filter
package fir_pkg;

    localparam int DATA_W     = 16;
    localparam int COEF_W     = 16;
    localparam int NREG       = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int LINE_DEPTH = 8;
    localparam int SLOT_W     = 3;
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 15;
    localparam int TAPS_DEF   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_OUT
    } t_state;

endpackage

@@ hw/rtl/fir_in_if.sv @@
// sample input channel
interface fir_in_if import fir_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

@@ hw/rtl/fir_out_if.sv @@
// filtered result channel
interface fir_out_if import fir_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink (input valid, input filtered_out, output ready);
endinterface

@@ hw/rtl/fir_cfg_if.sv @@
// coefficient write channel
interface fir_cfg_if import fir_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic signed [COEF_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/fir_filter_circular.sv @@
// circular delay line fir filter with one shared multiply-accumulate
//
// channels: i_sample takes one signed 16-bit sample per transaction,
// o_result gives one signed 16-bit filtered sample per input transaction,
// i_cfg writes the Q1.15 weights coef_tap0..coef_tap7 at index 0..7
// (other indexes are ignored); write weights only while the filter is idle.
// each sample is stored in the delay line, then one multiplier and one
// accumulator step through the TAPS window entries, oldest first, one tap
// per cycle. the sum is shifted right 15 and saturated to 16 bits.
// after the input transaction the fsm runs ST_MAC, ST_FLUSH and ST_OUT,
// then loads o_result; the single multiply-accumulate unit takes no new
// sample until then, as i_sample.ready is high only while idle.
// the result sits in an output register, so a new sample is taken while
// it waits; a stalled receiver holds back only the next result's load.
// reset clears the weights, the delay line, the write slot and o_result.valid.
`include "assert_macros.svh"

module fir_filter_circular import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fir_in_if.sink    i_sample,
    fir_cfg_if.sink   i_cfg,
    fir_out_if.source o_result
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TAPS - 1);

    t_state                   r_state, n_state;
    logic signed [COEF_W-1:0] r_coef [NREG];
    logic signed [DATA_W-1:0] r_line [LINE_DEPTH];
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        r_rd;
    logic [SLOT_W-1:0]        r_k;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out;

    logic                           in_fire;
    logic                           out_load;
    logic [SLOT_W-1:0]              slot_inc;
    logic [SLOT_W-1:0]              rd_inc;
    logic signed [ACC_W-FRAC_W-1:0] acc_shr;
    logic signed [DATA_W-1:0]       sat_val;

    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_sample.valid && i_sample.ready;
    assign slot_inc    = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign rd_inc      = (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;

    // floor shift, then clamp to 16 bits
    always_comb begin
        acc_shr = r_acc[ACC_W-1:FRAC_W];
        if (acc_shr[ACC_W-FRAC_W-1:DATA_W-1] == '0 ||
            acc_shr[ACC_W-FRAC_W-1:DATA_W-1] == '1) begin
            sat_val = acc_shr[DATA_W-1:0];
        end else if (acc_shr[ACC_W-FRAC_W-1]) begin
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_MAC;
            ST_MAC:   if (r_k == LAST_SLOT) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || o_result.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_sample.ready = 1'b0;
        out_load       = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_sample.ready = 1'b1;
            ST_MAC:   ;
            ST_FLUSH: ;
            ST_OUT:   out_load = !r_out_valid || o_result.ready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_prod_vld  <= 1'b0;
            for (int i = 0; i < NREG; i++) r_coef[i] <= '0;
            for (int i = 0; i < LINE_DEPTH; i++) r_line[i] <= '0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= (r_state == ST_MAC);
            if (i_cfg.valid && i_cfg.index < CFG_IDX_W'(NREG)) begin
                r_coef[i_cfg.index[REG_IDX_W-1:0]] <= i_cfg.data;
            end
            if (in_fire) begin
                r_line[r_slot] <= i_sample.sample_in;
                r_slot         <= slot_inc;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shared multiply-accumulate datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd  <= slot_inc;
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (r_state == ST_MAC) begin
                r_prod <= PROD_W'(r_coef[r_k] * r_line[r_rd]);
                r_rd   <= rd_inc;
                r_k    <= r_k + 1'b1;
            end
            if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (out_load) begin
            r_out <= sat_val;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.filtered_out = r_out;

    `FIR_ASSERT(a_slot_range, i_clk, i_rst_n, {1'b0, r_slot} < (SLOT_W + 1)'(TAPS))
    `FIR_ASSERT(a_start_mac, i_clk, i_rst_n, in_fire |=> r_state == ST_MAC && r_k == '0)
    `FIR_ASSERT(a_rd_range, i_clk, i_rst_n, r_state == ST_MAC |-> {1'b0, r_rd} < (SLOT_W + 1)'(TAPS))
    `FIR_ASSERT(a_line_write, i_clk, i_rst_n, in_fire |=> r_line[$past(r_slot)] == $past(i_sample.sample_in))

endmodule

@@ tb/fir_filter_circular_tb.sv @@
// testbench for the circular fir filter: directed and random samples checked against a predictor
`timescale 1ns / 100ps

module fir_filter_circular_tb import fir_pkg::*; ();

    localparam int DUT_TAPS = TAPS_DEF;
    localparam int CLK_HALF = 6;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP0    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP7    = CFG_IDX_W'(7);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(NREG);

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0] COEF_MAX   = 16'sh7fff;
    localparam logic signed [COEF_W-1:0] COEF_MIN   = 16'sh8000;

    logic i_clk;
    logic i_rst_n;

    fir_in_if  sample_if ();
    fir_cfg_if cfg_if ();
    fir_out_if result_if ();

    fir_filter_circular #(
        .TAPS(DUT_TAPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_if),
        .i_cfg   (cfg_if),
        .o_result(result_if)
    );

    logic signed [COEF_W-1:0] coef_model [NREG];
    logic signed [DATA_W-1:0] line_model [LINE_DEPTH];
    logic [SLOT_W-1:0]        slot_model;
    logic signed [DATA_W-1:0] pending_outputs [$];

    int fail_count  = 0;
    bit sample_gaps = 1'b1;
    bit sink_stalls = 1'b1;

    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // writes the new sample into the window and returns the filter output
    function automatic logic signed [DATA_W-1:0] predict_filtered(
        input logic signed [DATA_W-1:0] x
    );
        longint acc;
        longint q;
        int     pos;
        acc = 0;
        line_model[slot_model] = x;
        slot_model = SLOT_W'((int'(slot_model) + 1) % DUT_TAPS);
        for (int k = 0; k < DUT_TAPS; k++) begin
            pos = (int'(slot_model) + k) % DUT_TAPS;
            acc += longint'(coef_model[k]) * longint'(line_model[pos]);
        end
        q = acc >>> FRAC_W;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                default: return -16'sd1;
            endcase
        end else if (r < 30) begin
            return DATA_W'($urandom_range(0, 511) - 256);
        end
        return DATA_W'($urandom);
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0: return COEF_MAX;
                1: return COEF_MIN;
                2: return '0;
                3: return 16'sd1;
                default: return -16'sd1;
            endcase
        end else if (r < 50) begin
            return COEF_W'($urandom_range(0, 8191) - 4096);
        end
        return COEF_W'($urandom);
    endfunction

    task automatic write_coef(
        input logic [CFG_IDX_W-1:0]     idx,
        input logic signed [COEF_W-1:0] value
    );
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < NREG) begin
            coef_model[idx] = value;
        end
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] x);
        int gap;
        gap = sample_gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            sample_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_if.valid     = 1'b1;
        sample_if.sample_in = x;
        do @(posedge i_clk); while (!sample_if.ready);
        pending_outputs.push_back(predict_filtered(x));
    endtask

    task automatic stop_samples();
        @(negedge i_clk);
        sample_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_samples();
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DUT_TAPS + 3) @(posedge i_clk);
    endtask

    // result sink with random stalls while sink_stalls is set
    initial begin
        int r;
        int run;
        bit hold;
        result_if.ready = 1'b0;
        forever begin
            if (!sink_stalls) begin
                hold = 1'b1;
                run  = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    hold = 1'b1;
                    run  = $urandom_range(1, 30);
                end else if (r < 92) begin
                    hold = 1'b0;
                    run  = $urandom_range(1, 3);
                end else begin
                    hold = 1'b0;
                    run  = $urandom_range(15, 60);
                end
            end
            @(negedge i_clk);
            result_if.ready = hold;
            repeat (run - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result transaction, filtered_out %0d",
                         $time, result_if.filtered_out);
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (result_if.filtered_out !== want) begin
                    $display("%0t: filtered_out expected %0d actual %0d",
                             $time, want, result_if.filtered_out);
                    fail_count++;
                end
            end
        end
    end

    // delay line must start cleared
    task automatic test_cleared_line();
        for (int k = 0; k < NREG; k++) begin
            write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), COEF_W'((k + 1) * 4000));
        end
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);
    endtask

    // impulse walks through the window, oldest weight first
    task automatic test_tap_order();
        wait_drained();
        for (int k = 0; k < NREG; k++) begin
            write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k),
                       COEF_W'((k % 2 == 1) ? -(k + 1) * 2048 : (k + 1) * 2048));
        end
        send_sample(SAMPLE_MAX);
        repeat (7) send_sample('0);
    endtask

    task automatic test_saturation();
        wait_drained();
        for (int k = 0; k < NREG; k++) begin
            write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), COEF_MAX);
        end
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_drained();
        for (int k = 0; k < NREG; k++) begin
            write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), COEF_MIN);
        end
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
    endtask

    // shift rounds toward minus infinity
    task automatic test_floor_shift();
        wait_drained();
        for (int k = 0; k < NREG; k++) begin
            write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), '0);
        end
        write_coef(REG_COEF_TAP7, 16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(SAMPLE_MIN);
    endtask

    // writes above the last weight index are dropped
    task automatic test_unused_index();
        wait_drained();
        for (int i = REG_UNUSED_FIRST; i < 2 ** CFG_IDX_W; i++) begin
            write_coef(CFG_IDX_W'(i), COEF_MAX);
        end
        send_sample(SAMPLE_MAX);
        send_sample(16'sd1234);
        send_sample(SAMPLE_MIN);
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            sample_gaps = (phase != 0);
            sink_stalls = (phase != 0) && (phase != 3);
            for (int k = 0; k < NREG; k++) begin
                if (phase == 6) begin
                    write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), COEF_MIN);
                end else if (phase == 7) begin
                    write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), COEF_MAX);
                end else begin
                    write_coef(REG_COEF_TAP0 + CFG_IDX_W'(k), rand_coef());
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                write_coef(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 7)),
                           COEF_W'($urandom));
            end
            for (int n = 0; n < 100; n++) begin
                if (n == 50) begin
                    stop_samples();
                    while (pending_outputs.size() != 0) @(posedge i_clk);
                end
                send_sample(rand_sample());
            end
        end
        sample_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.sample_in = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        for (int k = 0; k < NREG; k++) begin
            coef_model[k] = '0;
        end
        for (int k = 0; k < LINE_DEPTH; k++) begin
            line_model[k] = '0;
        end
        slot_model = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cleared_line();
        test_tap_order();
        test_saturation();
        test_floor_shift();
        test_unused_index();
        test_random_stream();

        wait_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
